// ===== rtl/psa_pkg.sv =====
// Shared constants, codes and types of the pool slot allocator.
package psa_pkg;

  localparam int unsigned POOL_SLOTS  = 32;
  localparam int unsigned SLOT_W      = 5;
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned SCAN_GROUP  = 8;
  localparam int unsigned SCAN_IDX_W  = 3;
  localparam int unsigned NUM_GROUPS  = POOL_SLOTS / SCAN_GROUP;
  localparam int unsigned GRP_W       = 2;

  localparam logic [CNT_W-1:0] POOL_SIZE_RESET = CNT_W'(POOL_SLOTS);
  localparam logic [GRP_W-1:0] LAST_GROUP      = GRP_W'(NUM_GROUPS - 1);

  localparam logic CMD_SPAWN   = 1'b0;
  localparam logic CMD_DESPAWN = 1'b1;

  localparam logic [1:0] STATUS_GRANT   = 2'd0;
  localparam logic [1:0] STATUS_RECYCLE = 2'd1;
  localparam logic [1:0] STATUS_NONE    = 2'd2;
  localparam logic [1:0] STATUS_DESPAWN = 2'd3;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
  } scan_res_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    logic [SLOT_W-1:0] data;
  } mem_wr_t;

endpackage

// ===== rtl/psa_if.sv =====
// Handshake channels for command items and result items.
interface psa_cmd_if;
  import psa_pkg::*;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [SLOT_W-1:0] slot;
  modport source (output valid, output cmd, output slot, input ready);
  modport sink (input valid, input cmd, input slot, output ready);
endinterface

interface psa_res_if;
  import psa_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [SLOT_W-1:0] granted_slot;
  modport source (output valid, output status, output granted_slot, input ready);
  modport sink (input valid, input status, input granted_slot, output ready);
endinterface

// ===== rtl/psa_free_scan.sv =====
// Finds the lowest free slot below the pool limit within one group of flags.
module psa_free_scan (
  input  logic [psa_pkg::SCAN_GROUP-1:0] flags_i,
  input  logic [psa_pkg::GRP_W-1:0]      grp_i,
  input  logic [psa_pkg::CNT_W-1:0]      limit_i,
  output psa_pkg::scan_res_t             res_o
);
  import psa_pkg::*;

  logic [SLOT_W-1:0] cand;

  always_comb begin
    res_o = '0;
    cand  = '0;
    for (int j = SCAN_GROUP - 1; j >= 0; j--) begin
      cand = {grp_i, SCAN_IDX_W'(j)};
      if (!flags_i[j] && ({1'b0, cand} < limit_i)) begin
        res_o.found = 1'b1;
        res_o.slot  = cand;
      end
    end
  end

endmodule

// ===== rtl/psa_order_mem.sv =====
// Spawn order list storage: one write port, one read port with registered data.
module psa_order_mem (
  input  logic                       clk_i,
  input  psa_pkg::mem_wr_t           wr_i,
  input  logic [psa_pkg::SLOT_W-1:0] raddr_i,
  output logic [psa_pkg::SLOT_W-1:0] rdata_o
);
  import psa_pkg::*;

  logic [SLOT_W-1:0] mem_q [POOL_SLOTS];
  logic [SLOT_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pool_slot_allocator_oldest_reclaim.sv =====
// Pool slot allocator with oldest-first reclaim: top level and sequencer.
// A despawn of an idle slot goes straight to the result; a grant scans the active flags
// (eight per cycle) and appends the slot; no slot follows a full scan over an empty list.
// A despawn of an active slot compacts the list; a recycle takes the oldest entry, compacts
// and appends it (compaction walks one list entry per cycle). One item is taken at a time.
// Reset (async, active low) clears all active flags, the list length, sequencer and output.
module pool_slot_allocator_oldest_reclaim (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      pool_size_we_i,
  input  logic [psa_pkg::CNT_W-1:0] pool_size_i,
  psa_cmd_if.sink                   item_i,
  psa_res_if.source                 result_o
);
  import psa_pkg::*;

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_READ0  = 3'd2;
  localparam logic [2:0] S_REMOVE = 3'd3;
  localparam logic [2:0] S_APPEND = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]            state_q, state_d;
  logic [POOL_SLOTS-1:0] active_q, active_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [GRP_W-1:0]      grp_q, grp_d;
  logic [SLOT_W-1:0]     target_q, target_d;
  logic [CNT_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic                  pend_q, pend_d;
  logic                  recycle_q, recycle_d;
  logic [1:0]            res_status_q, res_status_d;
  logic [SLOT_W-1:0]     res_slot_q, res_slot_d;
  logic                  out_valid_q, out_valid_d;
  logic [1:0]            out_status_q, out_status_d;
  logic [SLOT_W-1:0]     out_slot_q, out_slot_d;
  logic [CNT_W-1:0]      pool_size_q;

  logic [CNT_W-1:0]      limit;
  scan_res_t             scan_res;
  mem_wr_t               mem_wr;
  logic [SLOT_W-1:0]     mem_raddr;
  logic [SLOT_W-1:0]     mem_rdata;
  logic                  accept;

  // Pool sizes above the number of physical slots act as a full pool.
  assign limit = (pool_size_q > POOL_SIZE_RESET) ? POOL_SIZE_RESET : pool_size_q;

  // The scan unit looks at one group of eight active flags per cycle.
  psa_free_scan u_scan (
    .flags_i (active_q[{grp_q, SCAN_IDX_W'(0)} +: SCAN_GROUP]),
    .grp_i   (grp_q),
    .limit_i (limit),
    .res_o   (scan_res)
  );

  psa_order_mem u_order (
    .clk_i   (clk_i),
    .wr_i    (mem_wr),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign item_i.ready          = (state_q == S_IDLE);
  assign accept                = item_i.valid && item_i.ready;
  assign result_o.valid        = out_valid_q;
  assign result_o.status       = out_status_q;
  assign result_o.granted_slot = out_slot_q;

  always_comb begin
    state_d      = state_q;
    active_d     = active_q;
    count_d      = count_q;
    grp_d        = grp_q;
    target_d     = target_q;
    rd_ptr_d     = rd_ptr_q;
    wr_ptr_d     = wr_ptr_q;
    pend_d       = pend_q;
    recycle_d    = recycle_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_valid_d  = out_valid_q && !result_o.ready;
    mem_wr       = '0;
    mem_raddr    = rd_ptr_q[SLOT_W-1:0];

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          rd_ptr_d  = '0;
          wr_ptr_d  = '0;
          pend_d    = 1'b0;
          recycle_d = 1'b0;
          grp_d     = '0;
          if (item_i.cmd == CMD_DESPAWN) begin
            res_status_d = STATUS_DESPAWN;
            res_slot_d   = '0;
            target_d     = item_i.slot;
            // Only an active slot sits in the list, so only then is there work to do.
            if (active_q[item_i.slot]) begin
              active_d[item_i.slot] = 1'b0;
              state_d               = S_REMOVE;
            end else begin
              state_d = S_DONE;
            end
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (scan_res.found) begin
          active_d[scan_res.slot] = 1'b1;
          target_d                = scan_res.slot;
          res_status_d            = STATUS_GRANT;
          res_slot_d              = scan_res.slot;
          state_d                 = S_APPEND;
        end else if (grp_q == LAST_GROUP) begin
          if (count_q != '0) begin
            // Fetch the oldest list entry for reclaim.
            mem_raddr = '0;
            state_d   = S_READ0;
          end else begin
            res_status_d = STATUS_NONE;
            res_slot_d   = '0;
            state_d      = S_DONE;
          end
        end else begin
          grp_d = grp_q + GRP_W'(1);
        end
      end

      S_READ0: begin
        target_d            = mem_rdata;
        active_d[mem_rdata] = 1'b1;
        res_status_d        = STATUS_RECYCLE;
        res_slot_d          = mem_rdata;
        recycle_d           = 1'b1;
        state_d             = S_REMOVE;
      end

      S_REMOVE: begin
        // Compaction pass: read entry rd_ptr, and write the entry read in the
        // previous cycle back at wr_ptr unless it is the slot being removed.
        if (pend_q && (mem_rdata != target_q)) begin
          mem_wr.en   = 1'b1;
          mem_wr.addr = wr_ptr_q[SLOT_W-1:0];
          mem_wr.data = mem_rdata;
          wr_ptr_d    = wr_ptr_q + CNT_W'(1);
        end
        if (rd_ptr_q < count_q) begin
          rd_ptr_d = rd_ptr_q + CNT_W'(1);
          pend_d   = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            count_d = wr_ptr_q;
            state_d = recycle_q ? S_APPEND : S_DONE;
          end
        end
      end

      S_APPEND: begin
        if (count_q < POOL_SIZE_RESET) begin
          mem_wr.en   = 1'b1;
          mem_wr.addr = count_q[SLOT_W-1:0];
          mem_wr.data = target_q;
          count_d     = count_q + CNT_W'(1);
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_q || result_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = res_slot_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      pool_size_q <= POOL_SIZE_RESET;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (pool_size_we_i) begin
        pool_size_q <= pool_size_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q        <= grp_d;
    target_q     <= target_d;
    rd_ptr_q     <= rd_ptr_d;
    wr_ptr_q     <= wr_ptr_d;
    pend_q       <= pend_d;
    recycle_q    <= recycle_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
  end

endmodule

// ===== rtl/psa_checker.sv =====
// Port-level assertions for the pool slot allocator, bound to the top level.
module psa_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [1:0]                 out_status_i,
  input logic [psa_pkg::SLOT_W-1:0] out_slot_i
);
  import psa_pkg::*;

  // An accepted item leaves the sequencer busy, so input ready drops.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready one cycle after an accepted item");

  // Results that hand out no slot carry a zero slot field.
  a_zero_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i == STATUS_NONE || out_status_i == STATUS_DESPAWN)
    |-> out_slot_i == '0)
    else $error("nonzero slot on a result without a grant");

  // A stalled result stays valid and unchanged.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i)
    && $stable(out_slot_i))
    else $error("stalled result changed");

endmodule

bind pool_slot_allocator_oldest_reclaim psa_checker u_psa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (item_i.valid),
  .in_ready_i   (item_i.ready),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .out_status_i (result_o.status),
  .out_slot_i   (result_o.granted_slot)
);

// ===== sim/tb_top.sv =====
// Self-checking testbench of the pool slot allocator with oldest-first reclaim.
module tb_top;
  import psa_pkg::*;

  // Cycles to let pass before a register write once every result is back.
  localparam int unsigned SETTLE_CYCLES  = 48;
  // Length of the one long receiver hold-off that backs up the block.
  localparam int unsigned LONG_HOLD      = 200;
  // Cycles without an accepted item or a taken result before the run is declared hung.
  // The slowest legal item is a recycle over a full list, plus a sender gap and a
  // receiver stall, so the long hold-off dominates this bound.
  localparam int unsigned WATCHDOG_LIMIT = LONG_HOLD + 2000;
  localparam int unsigned PHASE_ITEMS    = 170;
  localparam int unsigned NUM_PHASES     = 10;
  localparam int unsigned MAX_REPORTS    = 10;

  // One result item as the block should present it.
  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
  } grant_t;

  // Tracks the allocator state from accepted commands and checks the results.
  // The active flags and the hand-out order are kept here exactly as the block
  // should keep them; each accepted command yields exactly one expected grant.
  class pool_tracker;
    logic [CNT_W-1:0]  pool_size;
    bit [POOL_SLOTS-1:0] active;
    logic [SLOT_W-1:0] order[$];
    grant_t            expected_grants[$];
    int unsigned       mismatches;

    function new();
      pool_size  = POOL_SIZE_RESET;
      active     = '0;
      mismatches = 0;
    endfunction

    function void set_pool_size(logic [CNT_W-1:0] value);
      pool_size = value;
    endfunction

    function int unsigned pending();
      return expected_grants.size();
    endfunction

    function void note_command(logic cmd, logic [SLOT_W-1:0] slot);
      grant_t            g;
      int unsigned       limit;
      int                free_idx;
      logic [SLOT_W-1:0] oldest;
      g.status = STATUS_DESPAWN;
      g.slot   = '0;
      if (cmd == CMD_DESPAWN) begin
        // A despawn of an idle slot leaves everything as it is.
        if (active[slot]) begin
          active[slot] = 1'b0;
          for (int i = order.size() - 1; i >= 0; i--) begin
            if (order[i] == slot) order.delete(i);
          end
        end
      end else begin
        // Sizes above the pool saturate to the pool.
        limit    = (pool_size > POOL_SLOTS) ? POOL_SLOTS : pool_size;
        free_idx = -1;
        for (int i = 0; i < limit; i++) begin
          if (!active[i] && free_idx < 0) free_idx = i;
        end
        if (free_idx >= 0) begin
          active[free_idx] = 1'b1;
          order.push_back(SLOT_W'(free_idx));
          g.status = STATUS_GRANT;
          g.slot   = SLOT_W'(free_idx);
        end else if (order.size() > 0) begin
          // The oldest entry is handed out again and moves to the tail,
          // even when it lies above the current pool size.
          oldest = order.pop_front();
          order.push_back(oldest);
          active[oldest] = 1'b1;
          g.status = STATUS_RECYCLE;
          g.slot   = oldest;
        end else begin
          g.status = STATUS_NONE;
        end
      end
      expected_grants.push_back(g);
    endfunction

    function void check_grant(logic [1:0] status, logic [SLOT_W-1:0] slot);
      grant_t g;
      if (expected_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: status %0d slot %0d", status, slot);
      end else begin
        g = expected_grants.pop_front();
        if (g.status !== status || g.slot !== slot) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: status exp %0d got %0d, slot exp %0d got %0d",
                     g.status, status, g.slot, slot);
        end
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             pool_size_we_i;
  logic [CNT_W-1:0] pool_size_i;

  psa_cmd_if item_ch ();
  psa_res_if res_ch ();

  pool_slot_allocator_oldest_reclaim dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pool_size_we_i (pool_size_we_i),
    .pool_size_i    (pool_size_i),
    .item_i         (item_ch),
    .result_o       (res_ch)
  );

  pool_tracker tracker = new();

  // Knobs shared by the stimulus and the receiver process.
  bit sender_gaps;
  bit receiver_stalls;
  bit long_hold_req;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Accepted items are observed at the rising edge, before the block updates.
  // Commands feed the tracker and results are checked against it.
  always @(posedge clk_i) begin
    if (item_ch.valid && item_ch.ready) tracker.note_command(item_ch.cmd, item_ch.slot);
    if (res_ch.valid && res_ch.ready) tracker.check_grant(res_ch.status, res_ch.granted_slot);
  end

  // Watchdog: a run in which nothing moves for too long is a failure.
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: ready changes at the falling edge only. Random stalls come while
  // stalls are enabled, and one long hold-off is taken on request so that the block
  // fills up and pushes back on its input.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        res_ch.ready <= 1'b0;
        for (int k = 1; k < LONG_HOLD; k++) @(negedge clk_i);
      end else if (receiver_stalls && $urandom_range(0, 6) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13) - 1) @(negedge clk_i);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Offers one command item and returns at the edge where it is accepted.
  // Valid stays high into the next item unless a gap lowers it.
  task automatic send_item(input logic cmd, input logic [SLOT_W-1:0] slot);
    @(negedge clk_i);
    item_ch.valid <= 1'b1;
    item_ch.cmd   <= cmd;
    item_ch.slot  <= slot;
    do @(posedge clk_i); while (!item_ch.ready);
  endtask

  task automatic sender_gap(input int unsigned cycles);
    @(negedge clk_i);
    item_ch.valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Waits until the block holds no work, then writes the pool size register.
  task automatic write_pool_size(input logic [CNT_W-1:0] value);
    @(negedge clk_i);
    item_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    pool_size_we_i <= 1'b1;
    pool_size_i    <= value;
    @(negedge clk_i);
    pool_size_we_i <= 1'b0;
    tracker.set_pool_size(value);
  endtask

  // A despawn mostly names a slot that is currently handed out, so that list
  // removal is exercised, and otherwise any slot at all.
  function automatic logic [SLOT_W-1:0] pick_despawn_slot();
    if (tracker.order.size() > 0 && $urandom_range(0, 9) < 8)
      return tracker.order[$urandom_range(0, tracker.order.size() - 1)];
    return SLOT_W'($urandom_range(0, POOL_SLOTS - 1));
  endfunction

  initial begin
    logic [CNT_W-1:0] phase_sizes[NUM_PHASES];
    int unsigned      spawn_pct;
    bit               is_spawn;

    item_ch.valid   = 1'b0;
    item_ch.cmd     = CMD_SPAWN;
    item_ch.slot    = '0;
    pool_size_we_i  = 1'b0;
    pool_size_i     = '0;
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    long_hold_req   = 1'b0;
    rst_ni          = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, reset pool size of the full pool. Despawns of idle slots
    // at both ends of the slot range, then a few grants and a reuse of a hole.
    send_item(CMD_DESPAWN, SLOT_W'(POOL_SLOTS - 1));
    send_item(CMD_DESPAWN, '0);
    send_item(CMD_SPAWN, '0);
    send_item(CMD_SPAWN, '1);
    send_item(CMD_SPAWN, '0);
    send_item(CMD_DESPAWN, SLOT_W'(1));
    send_item(CMD_SPAWN, '0);

    // Pool shrunk below the number of active slots: no free slot, so the
    // oldest entries are recycled, including one that lies above the pool,
    // and a slot above the pool can still be despawned.
    write_pool_size(CNT_W'(2));
    send_item(CMD_SPAWN, '0);
    send_item(CMD_SPAWN, '0);
    send_item(CMD_DESPAWN, SLOT_W'(2));
    send_item(CMD_SPAWN, '0);

    // Pool size zero: recycling while the list holds entries, then no slot.
    write_pool_size('0);
    send_item(CMD_DESPAWN, '0);
    send_item(CMD_SPAWN, '0);
    send_item(CMD_DESPAWN, SLOT_W'(1));
    send_item(CMD_SPAWN, '0);
    send_item(CMD_DESPAWN, SLOT_W'(POOL_SLOTS - 1));

    // Largest register value, which saturates to the full pool.
    write_pool_size('1);
    send_item(CMD_SPAWN, '0);
    send_item(CMD_SPAWN, '0);

    // Random part: one pool size per phase, extremes included. Each phase has
    // its own spawn share so that some phases run the pool full and recycle
    // while others drain it.
    phase_sizes = '{CNT_W'(32), CNT_W'(63), CNT_W'(1), CNT_W'(0), CNT_W'(17),
                    CNT_W'(33), CNT_W'(5), CNT_W'(31), CNT_W'(2), CNT_W'(8)};
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      write_pool_size(phase_sizes[phase]);
      spawn_pct = $urandom_range(25, 85);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // The last phase runs with no idling on either side. Elsewhere idling
        // is switched on and off in stretches.
        if (phase == NUM_PHASES - 1) begin
          sender_gaps     = 1'b0;
          receiver_stalls = 1'b0;
        end else if (n % 40 == 0) begin
          sender_gaps     = ($urandom_range(0, 3) != 0);
          receiver_stalls = ($urandom_range(0, 3) != 0);
        end
        // One long receiver hold-off while the sender keeps offering items.
        if (phase == 4) sender_gaps = 1'b0;
        if (phase == 4 && n == 20) long_hold_req = 1'b1;
        if (sender_gaps && $urandom_range(0, 5) == 0) sender_gap($urandom_range(1, 13));
        is_spawn = ($urandom_range(0, 99) < spawn_pct);
        if (is_spawn)
          send_item(CMD_SPAWN, SLOT_W'($urandom_range(0, POOL_SLOTS - 1)));
        else
          send_item(CMD_DESPAWN, pick_despawn_slot());
      end
    end

    // Drain: every expected result must come back, then a quiet margin in which
    // a stray result would still be caught.
    @(negedge clk_i);
    item_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
